// ===== rtl/core/psau_pkg.sv =====
// ---------------------------------------------------------------------------
// psau_pkg: shared types and constants for the scroll address unit
// Event codes, address field layout and the architectural state record.
// ---------------------------------------------------------------------------
package psau_pkg;

	localparam int ADDR_W   = 15;
	localparam int FINE_W   = 3;
	localparam int ACTION_W = 4;
	localparam int DATA_W   = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CTRL_WR   = 4'd0,
		ACT_SCROLL_WR = 4'd1,
		ACT_ADDR_WR   = 4'd2,
		ACT_STATUS_RD = 4'd3,
		ACT_DATA_ACC  = 4'd4,
		ACT_INC_X     = 4'd5,
		ACT_INC_Y     = 4'd6,
		ACT_COPY_H    = 4'd7,
		ACT_COPY_V    = 4'd8
	} action_t;

	// address masks (fine Y [14:12], nametable [11:10], coarse Y [9:5], coarse X [4:0])
	localparam logic [ADDR_W-1:0] COPY_H_MASK = 15'h041f;
	localparam logic [ADDR_W-1:0] COPY_V_MASK = 15'h7be0;

	localparam logic [4:0] COARSE_X_LAST  = 5'd31;
	localparam logic [4:0] COARSE_Y_LAST  = 5'd29; // last visible tile row
	localparam logic [4:0] COARSE_Y_MAX   = 5'd31;
	localparam logic [2:0] FINE_Y_LAST    = 3'd7;
	localparam logic [ADDR_W-1:0] STEP_ONE = 15'd1;
	localparam logic [ADDR_W-1:0] STEP_ROW = 15'd32;

	typedef struct packed {
		logic [ADDR_W-1:0] v;       // current address
		logic [ADDR_W-1:0] t;       // temporary address
		logic [FINE_W-1:0] fine_x;
		logic              toggle;  // 0: first write, 1: second write
		logic              inc32;
	} scroll_state_t;

endpackage

// ===== rtl/core/psau_event_if.sv =====
// ---------------------------------------------------------------------------
// psau_event_if: event channel
// valid/ready channel carrying one event code and its data byte per beat.
// ---------------------------------------------------------------------------
interface psau_event_if;
	logic                            valid;
	logic                            ready;
	logic [psau_pkg::ACTION_W-1:0]   action;
	logic [psau_pkg::DATA_W-1:0]     data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== rtl/core/psau_result_if.sv =====
// ---------------------------------------------------------------------------
// psau_result_if: result channel
// valid/ready channel carrying the scroll state after each event.
// ---------------------------------------------------------------------------
interface psau_result_if;
	logic                          valid;
	logic                          ready;
	logic [psau_pkg::ADDR_W-1:0]   vram_address;
	logic [psau_pkg::FINE_W-1:0]   fine_x_scroll;
	logic                          toggle_now;
	logic                          address_reloaded;

	modport source (output valid, output vram_address, output fine_x_scroll,
		output toggle_now, output address_reloaded, input ready);
	modport sink   (input valid, input vram_address, input fine_x_scroll,
		input toggle_now, input address_reloaded, output ready);
endinterface

// ===== rtl/core/psau_next.sv =====
// ---------------------------------------------------------------------------
// psau_next: next-state logic
// Applies one event to the scroll state; pure combinational.
// ---------------------------------------------------------------------------
module psau_next (
	input  psau_pkg::scroll_state_t         cur,
	input  logic [psau_pkg::ACTION_W-1:0]   action,
	input  logic [psau_pkg::DATA_W-1:0]     data_byte,
	output psau_pkg::scroll_state_t         nxt,
	output logic                            reloaded
);
	import psau_pkg::*;

	logic [4:0]        coarse_y;
	logic [ADDR_W-1:0] y_next;

	// vertical step: fine Y, then coarse Y with the attribute-row wrap rules
	always_comb begin
		coarse_y = cur.v[9:5];
		y_next   = cur.v;
		if (cur.v[14:12] != FINE_Y_LAST) begin
			y_next[14:12] = cur.v[14:12] + 3'd1;
		end else begin
			y_next[14:12] = '0;
			if (coarse_y == COARSE_Y_LAST) begin
				y_next[9:5] = '0;
				y_next[11]  = ~cur.v[11];
			end else if (coarse_y == COARSE_Y_MAX) begin
				y_next[9:5] = '0;
			end else begin
				y_next[9:5] = coarse_y + 5'd1;
			end
		end
	end

	always_comb begin
		nxt      = cur;
		reloaded = 1'b0;
		case (action)
			ACT_CTRL_WR: begin
				nxt.t[11:10] = data_byte[1:0];
				nxt.inc32    = data_byte[2];
			end
			ACT_SCROLL_WR: begin
				if (!cur.toggle) begin
					nxt.t[4:0]  = data_byte[7:3];
					nxt.fine_x  = data_byte[2:0];
					nxt.toggle  = 1'b1;
				end else begin
					nxt.t[14:12] = data_byte[2:0];
					nxt.t[9:5]   = data_byte[7:3];
					nxt.toggle   = 1'b0;
				end
			end
			ACT_ADDR_WR: begin
				if (!cur.toggle) begin
					nxt.t[13:8] = data_byte[5:0];
					nxt.t[14]   = 1'b0;
					nxt.toggle  = 1'b1;
				end else begin
					nxt.t[7:0] = data_byte;
					nxt.v      = {cur.t[14:8], data_byte};
					nxt.toggle = 1'b0;
					reloaded   = 1'b1;
				end
			end
			ACT_STATUS_RD: begin
				nxt.toggle = 1'b0;
			end
			ACT_DATA_ACC: begin
				nxt.v = cur.v + (cur.inc32 ? STEP_ROW : STEP_ONE);
			end
			ACT_INC_X: begin
				if (cur.v[4:0] == COARSE_X_LAST) begin
					nxt.v[4:0] = '0;
					nxt.v[10]  = ~cur.v[10];
				end else begin
					nxt.v[4:0] = cur.v[4:0] + 5'd1;
				end
			end
			ACT_INC_Y: begin
				nxt.v = y_next;
			end
			ACT_COPY_H: begin
				nxt.v = (cur.v & ~COPY_H_MASK) | (cur.t & COPY_H_MASK);
			end
			ACT_COPY_V: begin
				nxt.v = (cur.v & ~COPY_V_MASK) | (cur.t & COPY_V_MASK);
			end
			default: begin
				nxt      = cur;
				reloaded = 1'b0;
			end
		endcase
	end
endmodule

// ===== rtl/core/ppu_scroll_address_unit.sv =====
// ---------------------------------------------------------------------------
// ppu_scroll_address_unit: loopy scroll/address registers
// Current and temporary VRAM address, fine X and the shared write toggle.
// ---------------------------------------------------------------------------
// Usage:
//   evt (sink): one event per beat - CPU register writes/reads (ctrl, scroll,
//     addr, status, data port) and renderer steps (inc X, inc Y, copy H/V).
//     data_byte only matters for ctrl, scroll and addr writes; codes past
//     copy V are no-ops.
//   res (source): one beat per event, showing v, fine X and the toggle after
//     that event, plus a flag set when a second addr write reloaded v from t.
//   Timing: an accepted event is held in the event register, then its result
//     in the result register. Throughput: 1 event per clock while res.ready
//     is high, set by the combinational next-state logic between them.
//   Reset (arst_n low): v, t, fine X, toggle and increment mode go to zero,
//     both pipeline stages empty.
//   Stall: while res.ready is low the result register holds; one more event
//     may sit in the event register, then evt.ready drops. No beat is lost.
// ---------------------------------------------------------------------------
module ppu_scroll_address_unit (
	input  logic           clk,
	input  logic           arst_n,
	psau_event_if.sink     evt,
	psau_result_if.source  res
);
	import psau_pkg::*;

	// stage 1: registered event
	logic                s1_valid;
	logic [ACTION_W-1:0] action_s1;
	logic [DATA_W-1:0]   data_s1;

	// architectural state, updated as an event leaves stage 1
	scroll_state_t state_q;
	scroll_state_t state_next;
	logic          reloaded_next;

	// stage 2: result register
	logic              s2_valid;
	logic [ADDR_W-1:0] vaddr_s2;
	logic [FINE_W-1:0] fine_x_s2;
	logic              toggle_s2;
	logic              reloaded_s2;

	logic s2_free;
	logic s1_adv;

	assign s2_free   = !s2_valid || res.ready;
	assign s1_adv    = s1_valid && s2_free;
	assign evt.ready = !s1_valid || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (evt.ready) begin
			s1_valid <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			action_s1 <= evt.action;
			data_s1   <= evt.data_byte;
		end
	end

	psau_next u_next (
		.cur       (state_q),
		.action    (action_s1),
		.data_byte (data_s1),
		.nxt       (state_next),
		.reloaded  (reloaded_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_adv) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_free) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			vaddr_s2    <= state_next.v;
			fine_x_s2   <= state_next.fine_x;
			toggle_s2   <= state_next.toggle;
			reloaded_s2 <= reloaded_next;
		end
	end

	assign res.valid            = s2_valid;
	assign res.vram_address     = vaddr_s2;
	assign res.fine_x_scroll    = fine_x_s2;
	assign res.toggle_now       = toggle_s2;
	assign res.address_reloaded = reloaded_s2;

	// state only moves when an event is retired into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(state_q))
		else $error("scroll state changed without a retired event");

	// the presented result always mirrors the live state
	a_result_match: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid |-> (vaddr_s2 == state_q.v && fine_x_s2 == state_q.fine_x
			&& toggle_s2 == state_q.toggle))
		else $error("result register out of step with state");

	// a reload only happens on the second address write, which clears the toggle
	a_reload_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid && reloaded_s2 |-> !toggle_s2 && vaddr_s2 == state_q.t)
		else $error("reload flag without v == t and toggle clear");

	// a retired event always lands in the result register
	a_retire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> s2_valid)
		else $error("retired event did not produce a result beat");
endmodule
